// ----- sv/mps_pkg.sv -----
// ----------------------------------------------------------------------------
// Modem power sequencer package
// Shared types, register indexes, reset values and timer helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

    // Timer and register widths
    localparam int TIMER_W   = 16;
    localparam int CFG_W     = 16;
    localparam int LIMIT_W   = 6;
    localparam int CFG_IDX_W = 4;
    localparam int LOAD_W    = (CFG_W > TIMER_W) ? CFG_W : TIMER_W;

    // Register reset values
    localparam logic [CFG_W-1:0]   RST_OFF_PRESS  = CFG_W'(1100);
    localparam logic [CFG_W-1:0]   RST_ON_PRESS   = CFG_W'(2048);
    localparam logic [CFG_W-1:0]   RST_RELEASE    = CFG_W'(700);
    localparam logic [CFG_W-1:0]   RST_RST_PULSE  = CFG_W'(20);
    localparam logic [CFG_W-1:0]   RST_OFF_POLL   = CFG_W'(200);
    localparam logic [LIMIT_W-1:0] RST_OFF_LIMIT  = LIMIT_W'(20);
    localparam logic [CFG_W-1:0]   RST_ALIVE_POLL = CFG_W'(50);
    localparam logic [CFG_W-1:0]   RST_HOLDOFF    = CFG_W'(5000);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFF_PRESS  = 4'd0,
        CFG_ON_PRESS   = 4'd1,
        CFG_RELEASE    = 4'd2,
        CFG_RST_PULSE  = 4'd3,
        CFG_OFF_POLL   = 4'd4,
        CFG_OFF_LIMIT  = 4'd5,
        CFG_ALIVE_POLL = 4'd6,
        CFG_HOLDOFF    = 4'd7
    } t_cfg_idx;

    // Command codes
    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_UP    = 3'd1,
        MODE_DOWN  = 3'd2,
        MODE_RESET = 3'd3,
        MODE_FLASH = 3'd4
    } t_mode;

    // Sequencer steps, reported as phase
    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_OFF_HOLD  = 4'd1,
        ST_OFF_POLL  = 4'd2,
        ST_UP_LOW    = 4'd3,
        ST_UP_HIGH   = 4'd4,
        ST_UP_WAIT   = 4'd5,
        ST_RST_PULSE = 4'd6,
        ST_RST_WAIT  = 4'd7
    } t_step;

    typedef struct packed {
        logic [CFG_W-1:0]   off_press_ticks;
        logic [CFG_W-1:0]   on_press_ticks;
        logic [CFG_W-1:0]   release_ticks;
        logic [CFG_W-1:0]   reset_pulse_ticks;
        logic [CFG_W-1:0]   off_poll_ticks;
        logic [LIMIT_W-1:0] off_poll_limit;
        logic [CFG_W-1:0]   alive_poll_ticks;
        logic [CFG_W-1:0]   holdoff_ticks;
    } t_cfg;

    typedef struct packed {
        logic       key;
        logic       rst;
        logic       force_off;
        logic       vbus;
        logic       flash;
    } t_pins;

    typedef struct packed {
        logic [2:0] mode;
        logic       alive_level;
    } t_item;

    typedef struct packed {
        logic       key_level;
        logic       reset_level;
        logic       force_off_level;
        logic       vbus_level;
        logic       flash_level;
        logic       busy_res;
        logic [3:0] phase;
        logic       alert;
        logic       forced_off;
        logic       rejected;
    } t_result;

    // Turn a programmed duration into a timer load: zero acts as one,
    // anything above the timer range saturates
    function automatic logic [TIMER_W-1:0] load_time(input logic [CFG_W-1:0] v);
        logic [LOAD_W-1:0] v_ext;
        logic [LOAD_W-1:0] tmax_ext;
        v_ext    = LOAD_W'(v);
        tmax_ext = LOAD_W'({TIMER_W{1'b1}});
        if (v_ext == '0) begin
            load_time = TIMER_W'(1);
        end else if (v_ext > tmax_ext) begin
            load_time = {TIMER_W{1'b1}};
        end else begin
            load_time = TIMER_W'(v_ext);
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/mps_cfg.sv -----
// ----------------------------------------------------------------------------
// Modem power sequencer configuration registers
// Holds the timing registers written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_cfg
    import mps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [CFG_W-1:0]     i_wr_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // Write one register per transaction; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.off_press_ticks   <= RST_OFF_PRESS;
            r_cfg.on_press_ticks    <= RST_ON_PRESS;
            r_cfg.release_ticks     <= RST_RELEASE;
            r_cfg.reset_pulse_ticks <= RST_RST_PULSE;
            r_cfg.off_poll_ticks    <= RST_OFF_POLL;
            r_cfg.off_poll_limit    <= RST_OFF_LIMIT;
            r_cfg.alive_poll_ticks  <= RST_ALIVE_POLL;
            r_cfg.holdoff_ticks     <= RST_HOLDOFF;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_OFF_PRESS:  r_cfg.off_press_ticks   <= i_wr_data;
                CFG_ON_PRESS:   r_cfg.on_press_ticks    <= i_wr_data;
                CFG_RELEASE:    r_cfg.release_ticks     <= i_wr_data;
                CFG_RST_PULSE:  r_cfg.reset_pulse_ticks <= i_wr_data;
                CFG_OFF_POLL:   r_cfg.off_poll_ticks    <= i_wr_data;
                CFG_OFF_LIMIT:  r_cfg.off_poll_limit    <= i_wr_data[LIMIT_W-1:0];
                CFG_ALIVE_POLL: r_cfg.alive_poll_ticks  <= i_wr_data;
                CFG_HOLDOFF:    r_cfg.holdoff_ticks     <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- sv/mps_core.sv -----
// ----------------------------------------------------------------------------
// Modem power sequencer core
// Sequencer state, timers and pin registers; advances once per accepted tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_core
    import mps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_tick_en,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result   o_result
);

    t_step               r_step,          n_step;
    logic [TIMER_W-1:0]  r_step_timer,    n_step_timer;
    logic [LIMIT_W-1:0]  r_poll_count,    n_poll_count;
    logic                r_suppress,      n_suppress;
    logic [TIMER_W-1:0]  r_holdoff_timer, n_holdoff_timer;
    logic                r_last_alive;
    t_pins               r_pins,          n_pins;
    logic                r_then_up,       n_then_up;

    logic   alive;
    logic   busy;
    logic   alert;
    logic   rejected;
    logic   forced;
    logic   do_finish;
    logic   do_up;
    logic   do_check;
    logic   do_alive_check;
    logic   do_down;
    t_mode  mode;

    assign alive = i_item.alive_level;
    assign mode  = t_mode'(i_item.mode);
    assign busy  = (r_step != ST_IDLE);

    // Next state for one tick
    always_comb begin
        logic [LIMIT_W-1:0] pc;
        n_step          = r_step;
        n_step_timer    = r_step_timer;
        n_poll_count    = r_poll_count;
        n_suppress      = r_suppress;
        n_holdoff_timer = r_holdoff_timer;
        n_pins          = r_pins;
        n_then_up       = r_then_up;
        alert           = 1'b0;
        rejected        = 1'b0;
        forced          = 1'b0;
        do_finish       = 1'b0;
        do_up           = 1'b0;
        do_check        = 1'b0;
        do_alive_check  = 1'b0;
        do_down         = 1'b0;
        pc              = r_poll_count;

        // Run the holdoff window down
        if (r_holdoff_timer != '0) begin
            n_holdoff_timer = r_holdoff_timer - TIMER_W'(1);
            if (r_holdoff_timer == TIMER_W'(1)) begin
                n_suppress = 1'b0;
            end
        end

        // Report an alive falling edge outside the holdoff
        if (r_last_alive && !alive && !n_suppress) begin
            alert           = 1'b1;
            n_suppress      = 1'b1;
            n_holdoff_timer = load_time(i_cfg.holdoff_ticks);
        end

        if (busy) begin
            // Flag and drop commands while a sequence runs
            if (mode inside {MODE_UP, MODE_DOWN, MODE_RESET, MODE_FLASH}) begin
                rejected = 1'b1;
            end
            if (r_step_timer > TIMER_W'(1)) begin
                n_step_timer = r_step_timer - TIMER_W'(1);
            end else begin
                n_step_timer = '0;
                case (r_step)
                    ST_OFF_HOLD: begin
                        n_pins.key   = 1'b1;
                        n_step       = ST_OFF_POLL;
                        n_poll_count = '0;
                        pc           = '0;
                        do_check     = 1'b1;
                    end
                    ST_OFF_POLL: begin
                        do_check = 1'b1;
                    end
                    ST_UP_LOW: begin
                        n_pins.key   = 1'b1;
                        n_step       = ST_UP_HIGH;
                        n_step_timer = load_time(i_cfg.release_ticks);
                    end
                    ST_UP_HIGH: begin
                        n_pins.key     = 1'b0;
                        n_pins.rst     = 1'b1;
                        n_step         = ST_UP_WAIT;
                        do_alive_check = 1'b1;
                    end
                    ST_UP_WAIT: begin
                        do_alive_check = 1'b1;
                    end
                    ST_RST_PULSE: begin
                        n_pins.rst     = 1'b1;
                        n_step         = ST_RST_WAIT;
                        do_alive_check = 1'b1;
                    end
                    ST_RST_WAIT: begin
                        do_alive_check = 1'b1;
                    end
                    default: begin
                        n_step    = ST_IDLE;
                        n_then_up = 1'b0;
                    end
                endcase
            end
        end else begin
            // Start a new command
            case (mode)
                MODE_UP: begin
                    do_up = 1'b1;
                end
                MODE_DOWN: begin
                    do_down = 1'b1;
                end
                MODE_RESET: begin
                    if (alive) begin
                        n_suppress      = 1'b0;
                        n_holdoff_timer = '0;
                        n_pins.rst      = 1'b0;
                        n_step          = ST_RST_PULSE;
                        n_step_timer    = load_time(i_cfg.reset_pulse_ticks);
                    end
                end
                MODE_FLASH: begin
                    n_pins.flash = 1'b1;
                    n_then_up    = 1'b1;
                    do_down      = 1'b1;
                end
                default: ;
            endcase
        end

        // Begin shutdown: key low, supply off
        if (do_down) begin
            if (!alive) begin
                do_finish = 1'b1;
            end else begin
                n_suppress      = 1'b0;
                n_holdoff_timer = '0;
                n_pins.vbus     = 1'b0;
                n_pins.key      = 1'b0;
                n_poll_count    = '0;
                n_step          = ST_OFF_HOLD;
                n_step_timer    = load_time(i_cfg.off_press_ticks);
            end
        end

        // Shutdown poll: force off at the limit, finish once alive drops
        if (do_check) begin
            if (pc >= i_cfg.off_poll_limit) begin
                n_pins.force_off = 1'b1;
                forced           = 1'b1;
                do_finish        = 1'b1;
            end else if (!alive) begin
                do_finish = 1'b1;
            end else begin
                n_poll_count = pc + LIMIT_W'(1);
                n_step_timer = load_time(i_cfg.off_poll_ticks);
            end
        end

        // Wait for alive after power up or reset
        if (do_alive_check) begin
            if (alive) begin
                n_step = ST_IDLE;
            end else begin
                n_step_timer = load_time(i_cfg.alive_poll_ticks);
            end
        end

        // End of shutdown, chaining into power up for a flash restart
        if (do_finish) begin
            n_step = ST_IDLE;
            if (n_then_up) begin
                n_then_up = 1'b0;
                do_up     = 1'b1;
            end
        end

        // Begin power up: hold reset, supply on, key low
        if (do_up) begin
            if (alive) begin
                n_step = ST_IDLE;
            end else begin
                n_suppress       = 1'b1;
                n_holdoff_timer  = load_time(i_cfg.holdoff_ticks);
                n_pins.force_off = 1'b0;
                n_pins.rst       = 1'b0;
                n_pins.vbus      = 1'b1;
                n_pins.key       = 1'b0;
                n_step           = ST_UP_LOW;
                n_step_timer     = load_time(i_cfg.on_press_ticks);
            end
        end
    end

    // Result fields for this tick
    always_comb begin
        o_result.key_level       = n_pins.key;
        o_result.reset_level     = n_pins.rst;
        o_result.force_off_level = n_pins.force_off;
        o_result.vbus_level      = n_pins.vbus;
        o_result.flash_level     = n_pins.flash;
        o_result.busy_res        = (n_step != ST_IDLE);
        o_result.phase           = n_step;
        o_result.alert           = alert;
        o_result.forced_off      = forced;
        o_result.rejected        = rejected;
    end

    // Advance state on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step          <= ST_IDLE;
            r_step_timer    <= '0;
            r_poll_count    <= '0;
            r_suppress      <= 1'b0;
            r_holdoff_timer <= '0;
            r_last_alive    <= 1'b0;
            r_pins          <= '{key: 1'b0, rst: 1'b1, force_off: 1'b0,
                                 vbus: 1'b0, flash: 1'b0};
            r_then_up       <= 1'b0;
        end else if (i_tick_en) begin
            r_step          <= n_step;
            r_step_timer    <= n_step_timer;
            r_poll_count    <= n_poll_count;
            r_suppress      <= n_suppress;
            r_holdoff_timer <= n_holdoff_timer;
            r_last_alive    <= alive;
            r_pins          <= n_pins;
            r_then_up       <= n_then_up;
        end
    end

endmodule

`default_nettype wire

// ----- sv/modem_power_sequencer.sv -----
// ----------------------------------------------------------------------------
// Modem power sequencer
// Timed power key, reset and supply sequences for a companion modem.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on i_in_* is one millisecond tick carrying an
//   optional command (power up, shutdown, reset, flash restart) and the
//   sampled modem alive pin. Every tick yields exactly one result
//   transaction on o_out_* with the pin levels, the current phase and the
//   alert, forced-off and rejected flags for that tick.
//   The result of a tick is registered at the edge that accepts it, and
//   one tick is accepted per cycle while the receiver does not stall; the
//   sequencer state and result register update in the same cycle from short logic.
//   When the receiver stalls, the result register holds and i_in_ready
//   drops until the result is taken; a tick is still accepted in the cycle
//   the pending result leaves.
//   Timing registers are written through i_cfg_* (index, data) and are
//   always ready; write them only while no tick is in flight.
//   Reset (synchronous, active low) returns the sequencer to idle with the
//   reset pin high, all other pins low and registers at their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module modem_power_sequencer
    import mps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_item                i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_result                   o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_result core_result;
    logic    tick_en;
    logic    r_out_valid;
    t_result r_out_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign tick_en     = i_in_valid && o_in_ready;

    mps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    mps_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick_en (tick_en),
        .i_item    (i_in_data),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_en) begin
            r_out_data <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modem power sequencer testbench
// Drives millisecond ticks with commands and alive samples through the
// valid/ready input channel. Predicts every result transaction from a
// local model of the sequencer and compares it field by field. Register
// settings change between test phases, from all-minimum up to the largest
// poll limit and holdoff window.
// ----------------------------------------------------------------------------
module tb;
    import mps_pkg::*;

    localparam int     CLK_HALF   = 6;
    localparam longint TIMEOUT_NS = 64'd24_000_000;

    // DUT connections
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_item                in_item   = '0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_result              out_item;
    logic                 cfg_valid = 1'b0;
    t_cfg_idx             cfg_index = CFG_OFF_PRESS;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 cfg_ready;

    // Sequencer state as predicted, with register copies at reset values
    t_cfg timing = '{RST_OFF_PRESS, RST_ON_PRESS, RST_RELEASE, RST_RST_PULSE,
                     RST_OFF_POLL, RST_OFF_LIMIT, RST_ALIVE_POLL, RST_HOLDOFF};
    t_step              seq_step       = ST_IDLE;
    logic [TIMER_W-1:0] seq_timer      = '0;
    logic [LIMIT_W-1:0] off_polls      = '0;
    logic               hold_quiet     = 1'b0;
    logic [TIMER_W-1:0] holdoff_left   = '0;
    logic               prev_alive     = 1'b0;
    t_pins              pin_state      = '{key: 1'b0, rst: 1'b1, force_off: 1'b0,
                                           vbus: 1'b0, flash: 1'b0};
    logic               chain_power_up = 1'b0;
    logic               forced_now     = 1'b0;

    // Results still owed by the DUT, oldest first
    t_result pin_reports_due[$];

    bit idle_on   = 1'b1;
    int stall_left = 0;
    int errors    = 0;
    int ticks_checked = 0;
    int alerts_seen   = 0;
    int forced_seen   = 0;
    int rejects_seen  = 0;
    int settings_used = 1;

    modem_power_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // Mostly short gaps, now and then a long one, none while idling is off
    function automatic int gap_len();
        int roll;
        if (!idle_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 9);
        return $urandom_range(10, 30);
    endfunction

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Zero duration counts as one tick
    function automatic logic [TIMER_W-1:0] ticks_of(input logic [CFG_W-1:0] v);
        return (v == '0) ? TIMER_W'(1) : TIMER_W'(v);
    endfunction

    function automatic void begin_power_up(input logic alive);
        if (alive) begin
            seq_step = ST_IDLE;
        end else begin
            hold_quiet          = 1'b1;
            holdoff_left        = ticks_of(timing.holdoff_ticks);
            pin_state.force_off = 1'b0;
            pin_state.rst       = 1'b0;
            pin_state.vbus      = 1'b1;
            pin_state.key       = 1'b0;
            seq_step            = ST_UP_LOW;
            seq_timer           = ticks_of(timing.on_press_ticks);
        end
    endfunction

    // Finish a shutdown; a flash restart continues with power up
    function automatic void end_shutdown(input logic alive);
        seq_step = ST_IDLE;
        if (chain_power_up) begin
            chain_power_up = 1'b0;
            begin_power_up(alive);
        end
    endfunction

    function automatic void poll_shutdown(input logic alive);
        if (off_polls >= timing.off_poll_limit) begin
            pin_state.force_off = 1'b1;
            forced_now          = 1'b1;
            end_shutdown(alive);
        end else if (!alive) begin
            end_shutdown(alive);
        end else begin
            off_polls = off_polls + LIMIT_W'(1);
            seq_timer = ticks_of(timing.off_poll_ticks);
        end
    endfunction

    function automatic void wait_alive(input logic alive);
        if (alive) begin
            seq_step = ST_IDLE;
        end else begin
            seq_timer = ticks_of(timing.alive_poll_ticks);
        end
    endfunction

    function automatic void begin_shutdown(input logic alive);
        if (!alive) begin
            end_shutdown(alive);
        end else begin
            hold_quiet     = 1'b0;
            holdoff_left   = '0;
            pin_state.vbus = 1'b0;
            pin_state.key  = 1'b0;
            off_polls      = '0;
            seq_step       = ST_OFF_HOLD;
            seq_timer      = ticks_of(timing.off_press_ticks);
        end
    endfunction

    // Advance the predicted sequencer by one tick and build its result
    function automatic t_result predict_tick(input t_item it);
        t_result r;
        logic    alive;
        logic    busy;
        alive      = it.alive_level;
        busy       = (seq_step != ST_IDLE);
        r          = '0;
        forced_now = 1'b0;

        // Count down the alert holdoff
        if (holdoff_left != '0) begin
            holdoff_left = holdoff_left - TIMER_W'(1);
            if (holdoff_left == '0) hold_quiet = 1'b0;
        end

        // Report a falling alive edge outside the holdoff
        if (prev_alive && !alive && !hold_quiet) begin
            r.alert      = 1'b1;
            hold_quiet   = 1'b1;
            holdoff_left = ticks_of(timing.holdoff_ticks);
        end

        if (busy) begin
            if (it.mode >= MODE_UP && it.mode <= MODE_FLASH) r.rejected = 1'b1;
            if (seq_timer > TIMER_W'(1)) begin
                seq_timer = seq_timer - TIMER_W'(1);
            end else begin
                seq_timer = '0;
                case (seq_step)
                    ST_OFF_HOLD: begin
                        pin_state.key = 1'b1;
                        seq_step      = ST_OFF_POLL;
                        off_polls     = '0;
                        poll_shutdown(alive);
                    end
                    ST_OFF_POLL: poll_shutdown(alive);
                    ST_UP_LOW: begin
                        pin_state.key = 1'b1;
                        seq_step      = ST_UP_HIGH;
                        seq_timer     = ticks_of(timing.release_ticks);
                    end
                    ST_UP_HIGH: begin
                        pin_state.key = 1'b0;
                        pin_state.rst = 1'b1;
                        seq_step      = ST_UP_WAIT;
                        wait_alive(alive);
                    end
                    ST_RST_PULSE: begin
                        pin_state.rst = 1'b1;
                        seq_step      = ST_RST_WAIT;
                        wait_alive(alive);
                    end
                    ST_UP_WAIT, ST_RST_WAIT: wait_alive(alive);
                    default: begin
                        seq_step       = ST_IDLE;
                        chain_power_up = 1'b0;
                    end
                endcase
            end
        end else begin
            case (it.mode)
                MODE_UP:   begin_power_up(alive);
                MODE_DOWN: begin_shutdown(alive);
                MODE_RESET: begin
                    if (alive) begin
                        hold_quiet    = 1'b0;
                        holdoff_left  = '0;
                        pin_state.rst = 1'b0;
                        seq_step      = ST_RST_PULSE;
                        seq_timer     = ticks_of(timing.reset_pulse_ticks);
                    end
                end
                MODE_FLASH: begin
                    pin_state.flash = 1'b1;
                    chain_power_up  = 1'b1;
                    begin_shutdown(alive);
                end
                default: ;
            endcase
        end

        prev_alive = alive;

        r.key_level       = pin_state.key;
        r.reset_level     = pin_state.rst;
        r.force_off_level = pin_state.force_off;
        r.vbus_level      = pin_state.vbus;
        r.flash_level     = pin_state.flash;
        r.busy_res        = (seq_step != ST_IDLE);
        r.phase           = seq_step;
        r.forced_off      = forced_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic same_field(input string name, input logic [3:0] want,
                              input logic [3:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_report(input t_result want, input t_result got);
        same_field("key_level",       4'(want.key_level),       4'(got.key_level));
        same_field("reset_level",     4'(want.reset_level),     4'(got.reset_level));
        same_field("force_off_level", 4'(want.force_off_level), 4'(got.force_off_level));
        same_field("vbus_level",      4'(want.vbus_level),      4'(got.vbus_level));
        same_field("flash_level",     4'(want.flash_level),     4'(got.flash_level));
        same_field("busy_res",        4'(want.busy_res),        4'(got.busy_res));
        same_field("phase",           want.phase,               got.phase);
        same_field("alert",           4'(want.alert),           4'(got.alert));
        same_field("forced_off",      4'(want.forced_off),      4'(got.forced_off));
        same_field("rejected",        4'(want.rejected),        4'(got.rejected));
        ticks_checked++;
        alerts_seen  += int'(want.alert);
        forced_seen  += int'(want.forced_off);
        rejects_seen += int'(want.rejected);
    endtask

    // Take result transactions with random stalls and check each one
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (pin_reports_due.size() == 0) begin
                $error("result transaction with no tick outstanding: %p", out_item);
                errors++;
            end else begin
                want = pin_reports_due.pop_front();
                check_report(want, out_item);
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready  <= 1'b1;
            stall_left = gap_len();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one tick; returns at the edge that accepts it, valid left high
    task automatic send_tick(input logic [2:0] mode, input logic alive);
        int    gap;
        t_item it;
        gap            = gap_len();
        it.mode        = mode;
        it.alive_level = alive;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        pin_reports_due.push_back(predict_tick(it));
    endtask

    task automatic run_to_step(input t_step target, input logic alive);
        while (seq_step != target) send_tick(MODE_TICK, alive);
    endtask

    // Drop valid and hold until every result is back and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pin_reports_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_OFF_PRESS:  timing.off_press_ticks   = val;
            CFG_ON_PRESS:   timing.on_press_ticks    = val;
            CFG_RELEASE:    timing.release_ticks     = val;
            CFG_RST_PULSE:  timing.reset_pulse_ticks = val;
            CFG_OFF_POLL:   timing.off_poll_ticks    = val;
            CFG_OFF_LIMIT:  timing.off_poll_limit    = val[LIMIT_W-1:0];
            CFG_ALIVE_POLL: timing.alive_poll_ticks  = val;
            CFG_HOLDOFF:    timing.holdoff_ticks     = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_timing(input t_cfg c);
        settle();
        write_reg(CFG_OFF_PRESS,  c.off_press_ticks);
        write_reg(CFG_ON_PRESS,   c.on_press_ticks);
        write_reg(CFG_RELEASE,    c.release_ticks);
        write_reg(CFG_RST_PULSE,  c.reset_pulse_ticks);
        write_reg(CFG_OFF_POLL,   c.off_poll_ticks);
        write_reg(CFG_OFF_LIMIT,  CFG_W'(c.off_poll_limit));
        write_reg(CFG_ALIVE_POLL, c.alive_poll_ticks);
        write_reg(CFG_HOLDOFF,    c.holdoff_ticks);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset-value registers: idle pins, ignored preconditions, unused modes
    task automatic test_defaults_and_preconditions();
        send_tick(MODE_TICK, 1'b0);
        send_tick(MODE_UP, 1'b1);
        send_tick(MODE_DOWN, 1'b0);
        send_tick(MODE_RESET, 1'b0);
        send_tick(3'd5, 1'b1);
        send_tick(3'd6, 1'b0);
        send_tick(3'd7, 1'b1);
        send_tick(MODE_RESET, 1'b1);
        run_to_step(ST_IDLE, 1'b1);
        send_tick(MODE_TICK, 1'b0);
    endtask

    // Power up with zero durations; shutdown while busy is rejected
    task automatic test_power_up();
        t_cfg c;
        c = '{off_press_ticks: 16'd2, on_press_ticks: 16'd0, release_ticks: 16'd1,
              reset_pulse_ticks: 16'd3, off_poll_ticks: 16'd2, off_poll_limit: 6'd0,
              alive_poll_ticks: 16'd0, holdoff_ticks: 16'd4};
        program_timing(c);
        send_tick(MODE_UP, 1'b0);
        send_tick(MODE_DOWN, 1'b0);
        run_to_step(ST_UP_WAIT, 1'b0);
        send_tick(MODE_TICK, 1'b0);
        send_tick(MODE_TICK, 1'b0);
        send_tick(MODE_TICK, 1'b1);
    endtask

    // Poll limit of zero, a limit reached, and alive dropping while polling
    task automatic test_forced_off();
        send_tick(MODE_DOWN, 1'b1);
        run_to_step(ST_IDLE, 1'b1);
        settle();
        write_reg(CFG_OFF_LIMIT, 16'd3);
        send_tick(MODE_DOWN, 1'b1);
        run_to_step(ST_IDLE, 1'b1);
        send_tick(MODE_DOWN, 1'b1);
        run_to_step(ST_OFF_POLL, 1'b1);
        send_tick(MODE_TICK, 1'b0);
    endtask

    // Falling edges inside and after the holdoff window
    task automatic test_alert_holdoff();
        send_tick(MODE_TICK, 1'b1);
        send_tick(MODE_TICK, 1'b0);
        send_tick(MODE_TICK, 1'b1);
        send_tick(MODE_TICK, 1'b0);
        repeat (5) send_tick(MODE_TICK, 1'b0);
        send_tick(MODE_TICK, 1'b1);
        send_tick(MODE_TICK, 1'b0);
    endtask

    // A command on the tick the reset pulse ends is still rejected
    task automatic test_busy_reject();
        send_tick(MODE_RESET, 1'b1);
        while (!(seq_step == ST_RST_PULSE && seq_timer <= TIMER_W'(1)))
            send_tick(MODE_TICK, 1'b1);
        send_tick(MODE_UP, 1'b1);
        send_tick(MODE_FLASH, 1'b1);
        run_to_step(ST_IDLE, 1'b1);
    endtask

    // Flash restart: straight power up, shutdown then power up, forced off only
    task automatic test_flash_restart();
        send_tick(MODE_FLASH, 1'b0);
        run_to_step(ST_UP_WAIT, 1'b0);
        send_tick(MODE_TICK, 1'b1);
        send_tick(MODE_FLASH, 1'b1);
        run_to_step(ST_OFF_POLL, 1'b1);
        send_tick(MODE_TICK, 1'b0);
        run_to_step(ST_UP_WAIT, 1'b0);
        send_tick(MODE_TICK, 1'b1);
        send_tick(MODE_FLASH, 1'b1);
        run_to_step(ST_IDLE, 1'b1);
    endtask

    // Largest poll limit and a full-range holdoff window, without idling
    task automatic test_extremes();
        t_cfg c;
        c = '{off_press_ticks: 16'd1, on_press_ticks: 16'd2, release_ticks: 16'd2,
              reset_pulse_ticks: 16'd1, off_poll_ticks: 16'd1, off_poll_limit: 6'd63,
              alive_poll_ticks: 16'd2, holdoff_ticks: 16'hFFFF};
        program_timing(c);
        idle_on = 1'b0;
        send_tick(MODE_DOWN, 1'b1);
        run_to_step(ST_IDLE, 1'b1);
        send_tick(MODE_UP, 1'b0);
        run_to_step(ST_UP_WAIT, 1'b0);
        run_to_step(ST_IDLE, 1'b1);
        // Falling edge deep inside the holdoff stays quiet
        send_tick(MODE_TICK, 1'b0);
        idle_on = 1'b1;
    endtask

    // Random command streams over several register settings
    task automatic test_random();
        t_cfg       c;
        int         flip_pct;
        int         cmd_pct;
        logic [2:0] mode;
        logic       alive;
        alive = 1'b0;
        for (int p = 0; p < 4; p++) begin
            if (p == 0) begin
                c = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 6'd1, 16'd1, 16'd1};
            end else begin
                c.off_press_ticks   = CFG_W'($urandom_range(0, 6));
                c.on_press_ticks    = CFG_W'($urandom_range(0, 6));
                c.release_ticks     = CFG_W'($urandom_range(0, 6));
                c.reset_pulse_ticks = CFG_W'($urandom_range(0, 6));
                c.off_poll_ticks    = CFG_W'($urandom_range(0, 4));
                c.off_poll_limit    = LIMIT_W'($urandom_range(0, 5));
                c.alive_poll_ticks  = CFG_W'($urandom_range(0, 6));
                c.holdoff_ticks     = CFG_W'($urandom_range(0, 40));
                if ($urandom_range(0, 3) == 0) c.on_press_ticks = CFG_W'($urandom_range(7, 20));
            end
            program_timing(c);
            case (p)
                0:       flip_pct = 12;
                1:       flip_pct = 3;
                2:       flip_pct = 35;
                default: flip_pct = 8;
            endcase
            for (int n = 0; n < 320; n++) begin
                // Alternate stretches with and without idling
                if (n % 60 == 0) idle_on = ($urandom_range(0, 3) != 0);
                cmd_pct = (seq_step == ST_IDLE) ? 30 : 4;
                if ($urandom_range(0, 99) < cmd_pct) begin
                    if ($urandom_range(0, 9) != 0) mode = 3'($urandom_range(1, 4));
                    else mode = 3'($urandom_range(5, 7));
                end else begin
                    mode = MODE_TICK;
                end
                if ($urandom_range(0, 99) < flip_pct) alive = !alive;
                send_tick(mode, alive);
            end
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_defaults_and_preconditions();
        test_power_up();
        test_forced_off();
        test_alert_holdoff();
        test_busy_reject();
        test_flash_restart();
        test_extremes();
        test_random();
        settle();
        $display("Covered %0d ticks over %0d register settings: power up, shutdown, reset",
                 ticks_checked, settings_used);
        $display("and flash restart sequences with %0d alerts, %0d forced shutdowns, %0d rejects.",
                 alerts_seen, forced_seen, rejects_seen);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
